// File: rtl/core/egas_pkg.sv
package egas_pkg;

    localparam int SUM_W      = 40;
    localparam int SUM_LO_W   = 20;
    localparam int REWARD_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int ARM_W      = 4;
    localparam int MAX_ARMS   = 16;
    localparam int CNT_CFG_W  = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_COUNT = 1'd1;

    localparam logic [FRAC_W-1:0]    EPSILON_RESET   = 16'd6554;
    localparam logic [CNT_CFG_W-1:0] ARM_COUNT_RESET = 5'd16;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    typedef enum logic [1:0] {
        HOW_REQUEST = 2'd0,
        HOW_EXPLORE = 2'd1,
        HOW_EXPLOIT = 2'd2
    } how_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_DECIDE,
        S_EXP_MUL,
        S_EXP_CMP,
        S_SEL_OUT
    } state_t;

endpackage

// File: rtl/core/egas_mean_cmp.sv
module egas_mean_cmp #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [egas_pkg::SUM_W-1:0] cand_s,
    input  logic        [COUNT_WIDTH:0]       cand_n,
    input  logic signed [egas_pkg::SUM_W-1:0] best_s,
    input  logic        [COUNT_WIDTH:0]       best_n,
    output logic                              greater
);
    import egas_pkg::*;

    localparam int NW    = COUNT_WIDTH + 1;
    localparam int HI_W  = SUM_W - SUM_LO_W;
    localparam int LO_PW = SUM_LO_W + NW;
    localparam int HI_PW = HI_W + NW + 1;
    localparam int DW    = SUM_W + NW + 2;

    logic        [LO_PW-1:0] a_lo;
    logic        [LO_PW-1:0] b_lo;
    logic signed [HI_PW-1:0] a_hi;
    logic signed [HI_PW-1:0] b_hi;
    logic        [LO_PW-1:0] a_lo_reg;
    logic        [LO_PW-1:0] b_lo_reg;
    logic signed [HI_PW-1:0] a_hi_reg;
    logic signed [HI_PW-1:0] b_hi_reg;
    logic        [DW-1:0]    diff;

    // sum split into unsigned low half and signed high half, four partial products
    assign a_lo = LO_PW'(cand_s[SUM_LO_W-1:0]) * LO_PW'(best_n);
    assign b_lo = LO_PW'(best_s[SUM_LO_W-1:0]) * LO_PW'(cand_n);
    assign a_hi = $signed(HI_PW'($signed(cand_s[SUM_W-1:SUM_LO_W])))
                * $signed(HI_PW'(best_n));
    assign b_hi = $signed(HI_PW'($signed(best_s[SUM_W-1:SUM_LO_W])))
                * $signed(HI_PW'(cand_n));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_lo_reg <= a_lo;
            b_lo_reg <= b_lo;
            a_hi_reg <= a_hi;
            b_hi_reg <= b_hi;
        end
    end

    // cand_s*best_n - best_s*cand_n, positive means candidate mean is higher
    assign diff = ((DW'(a_hi_reg) - DW'(b_hi_reg)) << SUM_LO_W)
                + DW'(a_lo_reg) - DW'(b_lo_reg);

    assign greater = !diff[DW-1] && (diff != '0);

endmodule

// File: rtl/core/epsilon_greedy_arm_selector.sv
// Epsilon-greedy arm selector.
// Input channel (in_valid/in_ready) carries one word: a record word (action 0)
// updates the success or failure count and the reward sum of one arm; a select
// word (action 1) produces one result word on the output channel
// (out_valid/out_ready) with the chosen arm and how it was chosen.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 epsilon,
// 1 arm count) in the same cycle; write only while the block is idle.
// Arm statistics live in a small synchronous RAM, one entry per arm.
// Steps, counted from the accepting edge:
//   record: read, then modify and write back
//   select, requested or explore: decide, then load the output register
//   select, exploit: decide, then scan the arms in use; the scan runs
//   one arm at a time through the shared cross-multiply compare unit
//   (partial product stage, then difference stage).
// Only one word is in progress at a time; in_ready is high when idle.
// A finished result sits in the output register; a stalled receiver holds the
// block in its last step until the previous result is taken.
// Reset clears all counts and sums at once (per-entry valid flags), sets
// epsilon to 6554 and the arm count to 16.
module epsilon_greedy_arm_selector #(
    parameter int NUM_ARMS    = 16,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [egas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [egas_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic [egas_pkg::ARM_W-1:0]            arm,
    input  logic                                  has_request,
    input  logic                                  success,
    input  logic signed [egas_pkg::REWARD_W-1:0]  reward,
    input  logic [egas_pkg::FRAC_W-1:0]           random_draw,
    input  logic [egas_pkg::FRAC_W-1:0]           random_pick,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [egas_pkg::ARM_W-1:0]            chosen_arm,
    output logic [1:0]                            how_chosen
);
    import egas_pkg::*;

    localparam int DEPTH     = (NUM_ARMS < MAX_ARMS) ? NUM_ARMS : MAX_ARMS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CW        = COUNT_WIDTH;
    localparam int NW        = COUNT_WIDTH + 1;
    localparam int WORD_W    = 2 * CW + NW + SUM_W;
    localparam int PLAYS_LSB = SUM_W;
    localparam int FAIL_LSB  = SUM_W + NW;
    localparam int SUCC_LSB  = SUM_W + NW + CW;
    localparam int PICK_W    = FRAC_W + CNT_CFG_W;
    localparam int SUM_EXT_W = SUM_W + 1;
    localparam logic [CNT_CFG_W-1:0] DEPTH_C = CNT_CFG_W'(DEPTH);

    state_t state_reg, state_next;

    logic [FRAC_W-1:0]    epsilon_reg;
    logic [CNT_CFG_W-1:0] arm_count_reg;
    logic [CNT_CFG_W-1:0] eff_count;

    logic                       item_has_request_reg;
    logic                       item_success_reg;
    logic [ARM_W-1:0]           item_arm_reg;
    logic signed [REWARD_W-1:0] item_reward_reg;
    logic [FRAC_W-1:0]          item_draw_reg;
    logic [FRAC_W-1:0]          item_pick_reg;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  entry_valid_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [WORD_W-1:0] wr_word;

    logic signed [SUM_W-1:0] rd_sum;
    logic [NW-1:0]           rd_plays;
    logic [CW-1:0]           rd_fail;
    logic [CW-1:0]           rd_succ;

    // record path
    logic                     arm_ok;
    logic signed [SUM_W-1:0]  old_sum;
    logic [NW-1:0]            old_plays;
    logic [CW-1:0]            old_fail;
    logic [CW-1:0]            old_succ;
    logic                     inc_succ;
    logic                     inc_fail;
    logic [CW-1:0]            new_succ;
    logic [CW-1:0]            new_fail;
    logic [NW-1:0]            new_plays;
    logic signed [SUM_EXT_W-1:0] sum_ext;
    logic [SUM_W-1:0]         new_sum;

    // select path
    logic             req_ok;
    logic             explore;
    logic [PICK_W-1:0] pick_prod;
    logic [ARM_W-1:0] decide_arm;
    how_t             decide_how;
    logic             decide_load;

    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              last_arm;
    logic              cmp_load;
    logic              best_load;
    logic              greater;

    logic signed [SUM_W-1:0] cand_s;
    logic [NW-1:0]           cand_n;
    logic signed [SUM_W-1:0] cand_s_reg;
    logic [NW-1:0]           cand_n_reg;
    logic signed [SUM_W-1:0] best_s_reg;
    logic [NW-1:0]           best_n_reg;

    logic [ARM_W-1:0] res_arm_reg;
    how_t             res_how_reg;
    logic             out_load;
    logic             out_valid_reg;
    logic [ARM_W-1:0] out_arm_reg;
    how_t             out_how_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg   <= EPSILON_RESET;
            arm_count_reg <= ARM_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_EPSILON)
                epsilon_reg <= cfg_data;
            else if (cfg_index == CFG_ARM_COUNT)
                arm_count_reg <= cfg_data[CNT_CFG_W-1:0];
        end
    end

    always_comb
    begin
        eff_count = arm_count_reg;
        if (eff_count == '0)
            eff_count = CNT_CFG_W'(1);
        if (eff_count > DEPTH_C)
            eff_count = DEPTH_C;
    end

    // accepted word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_has_request_reg <= has_request;
            item_success_reg     <= success;
            item_arm_reg         <= arm;
            item_reward_reg      <= reward;
            item_draw_reg        <= random_draw;
            item_pick_reg        <= random_pick;
        end
    end

    // arm statistics RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[item_arm_reg[ADDR_W-1:0]] <= wr_word;
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (mem_we)
                entry_valid_reg[item_arm_reg[ADDR_W-1:0]] <= 1'b1;
            rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    assign rd_sum   = $signed(rd_word_reg[SUM_W-1:0]);
    assign rd_plays = rd_word_reg[PLAYS_LSB +: NW];
    assign rd_fail  = rd_word_reg[FAIL_LSB +: CW];
    assign rd_succ  = rd_word_reg[SUCC_LSB +: CW];

    // read-modify-write of one arm, entries never written read as zero
    always_comb
    begin
        arm_ok    = 32'(item_arm_reg) < NUM_ARMS;
        old_sum   = rd_valid_reg ? rd_sum : '0;
        old_plays = rd_valid_reg ? rd_plays : '0;
        old_fail  = rd_valid_reg ? rd_fail : '0;
        old_succ  = rd_valid_reg ? rd_succ : '0;
        inc_succ  = item_success_reg && !(&old_succ);
        inc_fail  = !item_success_reg && !(&old_fail);
        new_succ  = old_succ + CW'(inc_succ);
        new_fail  = old_fail + CW'(inc_fail);
        new_plays = old_plays + NW'(inc_succ | inc_fail);
        sum_ext   = SUM_EXT_W'(old_sum) + SUM_EXT_W'(item_reward_reg);
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
            new_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        else
            new_sum = sum_ext[SUM_W-1:0];
        wr_word = {new_succ, new_fail, new_plays, new_sum};
    end

    // requested, explore or exploit decision
    always_comb
    begin
        req_ok    = item_has_request_reg && (CNT_CFG_W'(item_arm_reg) < eff_count);
        explore   = item_draw_reg < epsilon_reg;
        pick_prod = PICK_W'(item_pick_reg) * PICK_W'(eff_count);
        if (req_ok)
        begin
            decide_arm = item_arm_reg;
            decide_how = HOW_REQUEST;
        end
        else if (explore)
        begin
            decide_arm = pick_prod[FRAC_W +: ARM_W];
            decide_how = HOW_EXPLORE;
        end
        else
        begin
            decide_arm = '0;
            decide_how = HOW_EXPLOIT;
        end
    end

    // unplayed arm counts as mean 0 (sum 0 over one play)
    assign cand_s   = rd_valid_reg ? rd_sum : '0;
    assign cand_n   = rd_valid_reg ? rd_plays : NW'(1);
    assign last_arm = (CNT_CFG_W'(idx_reg) + CNT_CFG_W'(1)) == eff_count;

    egas_mean_cmp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mean_cmp (
        .clk     (clk),
        .load    (cmp_load),
        .cand_s  (cand_s),
        .cand_n  (cand_n),
        .best_s  (best_s_reg),
        .best_n  (best_n_reg),
        .greater (greater)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (action == ACT_RECORD) ? S_REC : S_DECIDE;
            end
            S_REC:
                state_next = S_IDLE;
            S_DECIDE:
            begin
                idx_next   = '0;
                state_next = (req_ok || explore) ? S_SEL_OUT : S_EXP_MUL;
            end
            S_EXP_MUL:
                state_next = S_EXP_CMP;
            S_EXP_CMP:
            begin
                if (last_arm)
                    state_next = S_SEL_OUT;
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_EXP_MUL;
                end
            end
            S_SEL_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        decide_load = 1'b0;
        cmp_load    = 1'b0;
        best_load   = 1'b0;
        out_load    = 1'b0;
        rd_addr     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = (action == ACT_RECORD) ? arm[ADDR_W-1:0] : '0;
            end
            S_REC:
                mem_we = arm_ok;
            S_DECIDE:
            begin
                decide_load = 1'b1;
                rd_addr     = '0;
            end
            S_EXP_MUL:
                cmp_load = 1'b1;
            S_EXP_CMP:
            begin
                // first arm always taken, later ones only on a strictly higher mean
                best_load = (idx_reg == '0) || greater;
                rd_addr   = idx_reg + ADDR_W'(1);
            end
            S_SEL_OUT:
                out_load = !out_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_load)
        begin
            cand_s_reg <= cand_s;
            cand_n_reg <= cand_n;
        end
        if (best_load)
        begin
            best_s_reg  <= cand_s_reg;
            best_n_reg  <= cand_n_reg;
            res_arm_reg <= ARM_W'(idx_reg);
        end
        else if (decide_load)
            res_arm_reg <= decide_arm;
        if (decide_load)
            res_how_reg <= decide_how;
        if (out_load)
        begin
            out_arm_reg <= res_arm_reg;
            out_how_reg <= res_how_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign chosen_arm = out_arm_reg;
    assign how_chosen = out_how_reg;

    a_write_only_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_REC)
        else $error("statistics write outside record step");

    a_mul_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXP_MUL |=> state_reg == S_EXP_CMP)
        else $error("product stage not followed by compare stage");

    a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL_OUT && out_valid_reg && !out_ready)
        |=> (state_reg == S_SEL_OUT && out_valid_reg))
        else $error("pending result overwritten while receiver stalls");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != S_IDLE)
        else $error("accepted word not taken into work");

endmodule
